// ===== hdl/kel_pkg.sv =====
// Shared constants, payload types and sequencer states for the key event latch.
package kel_pkg;

  // Slot layout: keyboard keys first, mouse buttons after them.
  localparam int KEYBOARD_KEYS = 128;
  localparam int MOUSE_BUTTONS = 3;
  localparam int RING_DEPTH    = 128;
  localparam int SLOT_COUNT    = KEYBOARD_KEYS + MOUSE_BUTTONS;
  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int RING_W        = $clog2(RING_DEPTH);

  // Flag bits of a slot word; bit 3 of the stored word is the held mark.
  localparam logic [2:0] FLAG_DOWN     = 3'b001;
  localparam logic [2:0] FLAG_PRESSED  = 3'b010;
  localparam logic [2:0] FLAG_RELEASED = 3'b100;
  localparam int         HELD_BIT      = 3;

  // Operation codes of an input item.
  typedef enum logic [2:0] {
    OP_KEY_DOWN     = 3'd0,
    OP_KEY_UP       = 3'd1,
    OP_BUTTON_DOWN  = 3'd2,
    OP_BUTTON_UP    = 3'd3,
    OP_FRAME_UPDATE = 3'd4,
    OP_QUERY_KEY    = 3'd5,
    OP_QUERY_BUTTON = 3'd6
  } op_e;

  // Input item.
  typedef struct packed {
    logic [2:0] op;
    logic [6:0] code;
  } req_t;

  // Result item.
  typedef struct packed {
    logic is_down;
    logic was_pressed;
    logic was_released;
  } rsp_t;

  // One ring entry: the slot and the flags of the recorded event.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [2:0]        flags;
  } ring_entry_t;

  // Access request to the slot store.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              we;
    logic [SLOT_W-1:0] wr_addr;
    logic [3:0]        wr_data;
  } slot_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_CHK,
    S_PUSH_DEC,
    S_OLD_WR,
    S_NEW_RD,
    S_NEW_WR,
    S_WALK_RD,
    S_WALK_DEC,
    S_WALK_WR,
    S_QRY_RD,
    S_QRY_OUT
  } state_e;

endpackage

// ===== hdl/key_event_latch_frame_flags.sv =====
// Top level of the key event latch: sequencer, event ring and result register.
//
// Usage: requests arrive on req_valid/req_ready/req, one operation per
// transfer. Key and button events update the per-slot down, pressed and
// released flags and are recorded in a ring. A frame update walks the ring
// from entry 0 up to the write pointer and ages the flags. Queries return
// one result on rsp_valid/rsp_ready/rsp; no other operation gives a result.
//
// Sequence: a key or button event steps through a check, a decode, a slot
// read and a write, with a step that clears the old slot before the read when
// the ring entry it overwrites is still occupied; a held key pressed again
// ends after the decode. A frame update does a ring read, a slot read and a
// write for each walked entry through the single slot memory port. A query
// reads its slot and then loads the registered result behind rsp_valid.
// Out-of-range codes end at once (events) or give an all-zero result
// (queries). req_ready is high only between items.
// Reset clears all flags, held marks, ring entries and the pointer at once
// through valid bits; no clearing pass is needed. A stalled receiver holds
// the result register; the next item is still taken, and a following query
// waits in its last step until the pending result has been transferred.
module key_event_latch_frame_flags (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  kel_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output kel_pkg::rsp_t   rsp
);

  localparam int SW = kel_pkg::SLOT_W;
  localparam int RW = kel_pkg::RING_W;

  kel_pkg::state_e state, state_next;

  // Sequencer registers.
  logic [RW-1:0] ring_pointer;
  logic [RW-1:0] walk_idx;
  logic [SW-1:0] cur_slot;
  logic [2:0]    cur_flags;
  logic          cur_key;
  logic          cur_hit;
  logic [SW-1:0] old_slot;
  logic [2:0]    old_flags;
  logic          old_valid;

  // Event ring.
  kel_pkg::ring_entry_t          ring_mem [kel_pkg::RING_DEPTH];
  logic [kel_pkg::RING_DEPTH-1:0] ring_valid;
  kel_pkg::ring_entry_t          ring_q;
  logic                          ring_vq;
  logic                          ring_rd_en;
  logic [RW-1:0]                 ring_rd_addr;
  logic                          ring_we;
  logic                          ring_clr;

  // Slot store port.
  kel_pkg::slot_req_t slot_req;
  logic [3:0]         slot_q;

  logic accept;
  logic rsp_load;
  logic walk_last;

  // Decode of the incoming item.
  logic          key_in_range;
  logic          btn_in_range;
  logic [SW-1:0] key_slot;
  logic [SW-1:0] btn_slot;
  logic          in_push;

  assign accept       = req_valid && req_ready;
  assign key_in_range = 32'(req.code) < kel_pkg::KEYBOARD_KEYS;
  assign btn_in_range = 32'(req.code) < kel_pkg::MOUSE_BUTTONS;
  assign key_slot     = SW'(req.code);
  assign btn_slot     = SW'(32'(kel_pkg::KEYBOARD_KEYS) + 32'(req.code));
  assign walk_last    = walk_idx == (ring_pointer - 1'b1);

  always_comb begin
    case (kel_pkg::op_e'(req.op))
      kel_pkg::OP_KEY_DOWN,
      kel_pkg::OP_KEY_UP:      in_push = key_in_range;
      kel_pkg::OP_BUTTON_DOWN,
      kel_pkg::OP_BUTTON_UP:   in_push = btn_in_range;
      default:                 in_push = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      kel_pkg::S_IDLE: begin
        if (accept) begin
          case (kel_pkg::op_e'(req.op))
            kel_pkg::OP_KEY_DOWN,
            kel_pkg::OP_KEY_UP,
            kel_pkg::OP_BUTTON_DOWN,
            kel_pkg::OP_BUTTON_UP: begin
              state_next = in_push ? kel_pkg::S_PUSH_CHK : kel_pkg::S_IDLE;
            end
            kel_pkg::OP_FRAME_UPDATE: begin
              state_next = (ring_pointer == '0) ? kel_pkg::S_IDLE : kel_pkg::S_WALK_RD;
            end
            kel_pkg::OP_QUERY_KEY,
            kel_pkg::OP_QUERY_BUTTON: state_next = kel_pkg::S_QRY_RD;
            default:                  state_next = kel_pkg::S_IDLE;
          endcase
        end
      end
      kel_pkg::S_PUSH_CHK: state_next = kel_pkg::S_PUSH_DEC;
      kel_pkg::S_PUSH_DEC: begin
        if (cur_key && cur_flags[1] && slot_q[kel_pkg::HELD_BIT]) begin
          state_next = kel_pkg::S_IDLE;
        end else if (ring_vq) begin
          state_next = kel_pkg::S_OLD_WR;
        end else begin
          state_next = kel_pkg::S_NEW_RD;
        end
      end
      kel_pkg::S_OLD_WR:   state_next = kel_pkg::S_NEW_RD;
      kel_pkg::S_NEW_RD:   state_next = kel_pkg::S_NEW_WR;
      kel_pkg::S_NEW_WR:   state_next = kel_pkg::S_IDLE;
      kel_pkg::S_WALK_RD:  state_next = kel_pkg::S_WALK_DEC;
      kel_pkg::S_WALK_DEC: state_next = kel_pkg::S_WALK_WR;
      kel_pkg::S_WALK_WR:  state_next = walk_last ? kel_pkg::S_IDLE : kel_pkg::S_WALK_RD;
      kel_pkg::S_QRY_RD:   state_next = kel_pkg::S_QRY_OUT;
      kel_pkg::S_QRY_OUT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = kel_pkg::S_IDLE;
        end
      end
      default:             state_next = kel_pkg::S_IDLE;
    endcase
  end

  // Control outputs of the sequencer, including the flag update unit of the frame walk.
  always_comb begin
    logic [2:0] walk_f;
    walk_f             = slot_q[2:0];
    if ((old_flags & kel_pkg::FLAG_RELEASED) != 3'b000) begin
      walk_f = 3'b000;
    end
    if ((old_flags & kel_pkg::FLAG_PRESSED) != 3'b000) begin
      walk_f = (walk_f & ~kel_pkg::FLAG_PRESSED) | kel_pkg::FLAG_DOWN;
    end

    req_ready        = 1'b0;
    ring_rd_en       = 1'b0;
    ring_rd_addr     = ring_pointer;
    ring_we          = 1'b0;
    ring_clr         = 1'b0;
    rsp_load         = 1'b0;
    slot_req.rd_en   = 1'b0;
    slot_req.rd_addr = cur_slot;
    slot_req.we      = 1'b0;
    slot_req.wr_addr = cur_slot;
    slot_req.wr_data = {slot_q[kel_pkg::HELD_BIT], slot_q[2:0] | cur_flags};
    case (state)
      kel_pkg::S_IDLE: req_ready = 1'b1;
      kel_pkg::S_PUSH_CHK: begin
        slot_req.rd_en = 1'b1;
        ring_rd_en     = 1'b1;
      end
      kel_pkg::S_PUSH_DEC: begin
        slot_req.rd_en   = ring_vq;
        slot_req.rd_addr = ring_q.slot;
      end
      kel_pkg::S_OLD_WR: begin
        slot_req.we      = 1'b1;
        slot_req.wr_addr = old_slot;
        slot_req.wr_data = {slot_q[kel_pkg::HELD_BIT], 3'b000};
      end
      kel_pkg::S_NEW_RD: slot_req.rd_en = 1'b1;
      kel_pkg::S_NEW_WR: begin
        slot_req.we = 1'b1;
        if (cur_key) begin
          slot_req.wr_data[kel_pkg::HELD_BIT] = cur_flags[1];
        end
        ring_we = 1'b1;
      end
      kel_pkg::S_WALK_RD: begin
        ring_rd_en   = 1'b1;
        ring_rd_addr = walk_idx;
      end
      kel_pkg::S_WALK_DEC: begin
        slot_req.rd_en   = ring_vq;
        slot_req.rd_addr = ring_q.slot;
      end
      kel_pkg::S_WALK_WR: begin
        slot_req.we      = old_valid;
        slot_req.wr_addr = old_slot;
        slot_req.wr_data = {slot_q[kel_pkg::HELD_BIT], walk_f};
        ring_clr         = 1'b1;
      end
      kel_pkg::S_QRY_RD: slot_req.rd_en = 1'b1;
      kel_pkg::S_QRY_OUT: rsp_load = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  // State, pointer and ring valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= kel_pkg::S_IDLE;
      ring_pointer <= '0;
      walk_idx     <= '0;
      ring_valid   <= '0;
      ring_vq      <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (ring_rd_en) begin
        ring_vq <= ring_valid[ring_rd_addr];
      end
      if (ring_we) begin
        ring_valid[ring_pointer] <= 1'b1;
        if (ring_pointer == RW'(kel_pkg::RING_DEPTH - 1)) begin
          ring_pointer <= '0;
        end else begin
          ring_pointer <= ring_pointer + 1'b1;
        end
      end
      if (accept) begin
        walk_idx <= '0;
      end
      if (ring_clr) begin
        ring_valid[walk_idx] <= 1'b0;
        if (walk_last) begin
          ring_pointer <= '0;
        end else begin
          walk_idx <= walk_idx + 1'b1;
        end
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_pointer] <= '{slot: cur_slot, flags: cur_flags};
    end
    if (ring_rd_en) begin
      ring_q <= ring_mem[ring_rd_addr];
    end
  end

  // Item decode and entry latches.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_key   <= 1'b0;
      cur_hit   <= 1'b0;
      cur_slot  <= '0;
      cur_flags <= kel_pkg::FLAG_RELEASED;
      case (kel_pkg::op_e'(req.op))
        kel_pkg::OP_KEY_DOWN: begin
          cur_key   <= 1'b1;
          cur_slot  <= key_slot;
          cur_flags <= kel_pkg::FLAG_PRESSED | kel_pkg::FLAG_DOWN;
        end
        kel_pkg::OP_KEY_UP: begin
          cur_key  <= 1'b1;
          cur_slot <= key_slot;
        end
        kel_pkg::OP_BUTTON_DOWN: begin
          cur_slot  <= btn_slot;
          cur_flags <= kel_pkg::FLAG_PRESSED | kel_pkg::FLAG_DOWN;
        end
        kel_pkg::OP_BUTTON_UP: cur_slot <= btn_slot;
        kel_pkg::OP_QUERY_KEY: begin
          cur_hit  <= key_in_range;
          cur_slot <= key_in_range ? key_slot : '0;
        end
        kel_pkg::OP_QUERY_BUTTON: begin
          cur_hit  <= btn_in_range;
          cur_slot <= btn_in_range ? btn_slot : '0;
        end
        default: ;
      endcase
    end
    if (state == kel_pkg::S_PUSH_DEC || state == kel_pkg::S_WALK_DEC) begin
      old_slot  <= ring_q.slot;
      old_flags <= ring_q.flags;
      old_valid <= ring_vq;
    end
    if (rsp_load) begin
      rsp.is_down      <= cur_hit && slot_q[0];
      rsp.was_pressed  <= cur_hit && slot_q[1];
      rsp.was_released <= cur_hit && slot_q[2];
    end
  end

  kel_slot_store u_slot_store (
    .clk     (clk),
    .rst     (rst),
    .req     (slot_req),
    .rd_data (slot_q)
  );

endmodule

// ===== hdl/kel_slot_store.sv =====
// Per-slot flag and held-mark memory with reset-cleared valid bits.
module kel_slot_store (
  input  logic                 clk,
  input  logic                 rst,
  input  kel_pkg::slot_req_t   req,
  output logic [3:0]           rd_data
);

  logic [3:0]                   mem [kel_pkg::SLOT_COUNT];
  logic [kel_pkg::SLOT_COUNT-1:0] valid;
  logic [3:0]                   mem_q;
  logic                         valid_q;

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (req.we) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        valid_q <= valid[req.rd_addr];
      end
    end
  end

  // Memory array with a registered read port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
  end

  assign rd_data = valid_q ? mem_q : 4'b0000;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the key event latch: directed, ring-wrap, stall and random tests.
`timescale 1ns / 100ps

module tb;

  // Op 7 is not decoded by the block; it must be swallowed without a result.
  localparam logic [2:0] OP_UNUSED    = 3'd7;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 400;
  localparam int         RANDOM_ITEMS = 1800;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  kel_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_ready;
  kel_pkg::rsp_t  rsp;

  // Shadow copy of the block state, updated as each request transfer happens.
  logic [2:0]        key_flags [kel_pkg::SLOT_COUNT];
  logic              key_held  [kel_pkg::KEYBOARD_KEYS];
  logic              log_valid [kel_pkg::RING_DEPTH];
  int                log_slot  [kel_pkg::RING_DEPTH];
  logic [2:0]        log_flags [kel_pkg::RING_DEPTH];
  int                log_ptr;

  // Query results still owed by the block, oldest first.
  kel_pkg::rsp_t     pending_flags [$];
  kel_pkg::rsp_t     want;

  // Stimulus controls shared between the tests and the two handshake processes.
  bit                req_gaps_on;
  bit                rsp_gaps_on;
  int                rsp_hold_cycles;

  int                error_count;
  int                items_sent;
  int                results_seen;
  int                frames_seen;
  int                wraps_seen;
  int                held_skips;
  int                range_skips;

  key_event_latch_frame_flags dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void report_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endfunction

  // Record one event in the ring; an occupied entry first wipes its old slot.
  function automatic void record_event(input int slot, input logic [2:0] fl);
    if (log_valid[log_ptr]) begin
      key_flags[log_slot[log_ptr]] = 3'b000;
    end
    log_valid[log_ptr] = 1'b1;
    log_slot[log_ptr]  = slot;
    log_flags[log_ptr] = fl;
    key_flags[slot]    = key_flags[slot] | fl;
    log_ptr++;
    if (log_ptr >= kel_pkg::RING_DEPTH) begin
      log_ptr = 0;
      wraps_seen++;
    end
  endfunction

  // Age the flags of every entry below the pointer, then empty those entries.
  function automatic void age_frame();
    int s;
    for (int i = 0; i < log_ptr; i++) begin
      if (log_valid[i]) begin
        s = log_slot[i];
        if ((log_flags[i] & kel_pkg::FLAG_RELEASED) != 3'b000) begin
          key_flags[s] = 3'b000;
        end
        if ((log_flags[i] & kel_pkg::FLAG_PRESSED) != 3'b000) begin
          key_flags[s] = (key_flags[s] & ~kel_pkg::FLAG_PRESSED) | kel_pkg::FLAG_DOWN;
        end
      end
      log_valid[i] = 1'b0;
      log_slot[i]  = 0;
      log_flags[i] = 3'b000;
    end
    log_ptr = 0;
    frames_seen++;
  endfunction

  // Apply one accepted request to the shadow state; queries owe one result.
  function automatic void predict_item(input logic [2:0] item_op, input logic [6:0] item_code);
    int            c;
    bit            is_query;
    logic [2:0]    f;
    kel_pkg::rsp_t r;
    c        = item_code;
    is_query = 1'b0;
    f        = 3'b000;
    case (item_op)
      kel_pkg::OP_KEY_DOWN: begin
        if (c >= kel_pkg::KEYBOARD_KEYS) begin
          range_skips++;
        end else if (key_held[c]) begin
          held_skips++;
        end else begin
          record_event(c, kel_pkg::FLAG_PRESSED | kel_pkg::FLAG_DOWN);
          key_held[c] = 1'b1;
        end
      end
      kel_pkg::OP_KEY_UP: begin
        if (c < kel_pkg::KEYBOARD_KEYS) begin
          record_event(c, kel_pkg::FLAG_RELEASED);
          key_held[c] = 1'b0;
        end else begin
          range_skips++;
        end
      end
      kel_pkg::OP_BUTTON_DOWN: begin
        if (c < kel_pkg::MOUSE_BUTTONS) begin
          record_event(kel_pkg::KEYBOARD_KEYS + c, kel_pkg::FLAG_PRESSED | kel_pkg::FLAG_DOWN);
        end else begin
          range_skips++;
        end
      end
      kel_pkg::OP_BUTTON_UP: begin
        if (c < kel_pkg::MOUSE_BUTTONS) begin
          record_event(kel_pkg::KEYBOARD_KEYS + c, kel_pkg::FLAG_RELEASED);
        end else begin
          range_skips++;
        end
      end
      kel_pkg::OP_FRAME_UPDATE: begin
        age_frame();
      end
      kel_pkg::OP_QUERY_KEY: begin
        is_query = 1'b1;
        if (c < kel_pkg::KEYBOARD_KEYS) f = key_flags[c];
      end
      kel_pkg::OP_QUERY_BUTTON: begin
        is_query = 1'b1;
        if (c < kel_pkg::MOUSE_BUTTONS) f = key_flags[kel_pkg::KEYBOARD_KEYS + c];
      end
      default: begin
      end
    endcase
    if (is_query) begin
      r.is_down      = f[0];
      r.was_pressed  = f[1];
      r.was_released = f[2];
      pending_flags  = {pending_flags, r};
    end
  endfunction

  // Offer one request and hold it until the transfer; valid stays high afterwards
  // so that a following call with no gap keeps it up without a dip.
  task automatic send_item(input logic [2:0] item_op, input logic [6:0] item_code);
    int            gap;
    kel_pkg::req_t item;
    gap = req_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.op   = item_op;
    item.code = item_code;
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_ready === 1'b1 && req_valid));
    predict_item(item_op, item_code);
    items_sent++;
  endtask

  // Result side: random or long stalls, then wait for one transfer.
  initial begin : receiver
    int stall;
    rsp_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rsp_hold_cycles > 0) begin
        stall           = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end else begin
        stall = rsp_gaps_on ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_ready));
    end
  end

  // Compare every result transfer with the oldest owed result.
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_ready) begin
      results_seen++;
      if (pending_flags.size() == 0) begin
        report_error($sformatf("result %b arrived with none outstanding", rsp));
      end else begin
        want = pending_flags.pop_front();
        if (rsp.is_down !== want.is_down || rsp.was_pressed !== want.was_pressed ||
            rsp.was_released !== want.was_released) begin
          report_error($sformatf("result %0d: down/pressed/released expected %b%b%b, got %b%b%b",
                                 results_seen, want.is_down, want.was_pressed,
                                 want.was_released, rsp.is_down, rsp.was_pressed,
                                 rsp.was_released));
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results still owed", CYCLE_LIMIT,
             pending_flags.size());
    $display("Verification failed");
    $finish;
  end

  // Presses of the lowest and highest keys and the outer buttons, releases of the highest key and the last button.
  task automatic test_flag_extremes();
    send_item(kel_pkg::OP_KEY_DOWN, 7'd0);
    send_item(kel_pkg::OP_KEY_DOWN, 7'd127);
    send_item(kel_pkg::OP_BUTTON_DOWN, 7'd0);
    send_item(kel_pkg::OP_BUTTON_DOWN, 7'd2);
    send_item(kel_pkg::OP_QUERY_KEY, 7'd127);
    send_item(kel_pkg::OP_QUERY_BUTTON, 7'd0);
    send_item(kel_pkg::OP_KEY_UP, 7'd127);
    send_item(kel_pkg::OP_BUTTON_UP, 7'd2);
    send_item(kel_pkg::OP_QUERY_KEY, 7'd127);
    send_item(kel_pkg::OP_FRAME_UPDATE, 7'd0);
    send_item(kel_pkg::OP_QUERY_KEY, 7'd0);
    send_item(kel_pkg::OP_QUERY_KEY, 7'd127);
    send_item(kel_pkg::OP_QUERY_BUTTON, 7'd2);
  endtask

  // A second press of a held key is dropped until the key is released.
  task automatic test_held_key();
    send_item(kel_pkg::OP_KEY_DOWN, 7'd5);
    send_item(kel_pkg::OP_KEY_DOWN, 7'd5);
    send_item(kel_pkg::OP_FRAME_UPDATE, 7'd0);
    send_item(kel_pkg::OP_QUERY_KEY, 7'd5);
    send_item(kel_pkg::OP_KEY_DOWN, 7'd5);
    send_item(kel_pkg::OP_KEY_UP, 7'd5);
    send_item(kel_pkg::OP_QUERY_KEY, 7'd5);
    send_item(kel_pkg::OP_FRAME_UPDATE, 7'd0);
    send_item(kel_pkg::OP_KEY_DOWN, 7'd5);
    send_item(kel_pkg::OP_QUERY_KEY, 7'd5);
  endtask

  // Button numbers past the last button and the undecoded op.
  task automatic test_ignored_codes();
    send_item(kel_pkg::OP_BUTTON_DOWN, 7'd3);
    send_item(kel_pkg::OP_BUTTON_UP, 7'd127);
    send_item(kel_pkg::OP_QUERY_BUTTON, 7'd3);
    send_item(kel_pkg::OP_QUERY_BUTTON, 7'd127);
    send_item(OP_UNUSED, 7'd127);
    send_item(OP_UNUSED, 7'd0);
  endtask

  // Overfill the ring so that the walk leaves entries past the pointer occupied.
  task automatic test_ring_wrap();
    req_gaps_on = 1'b1;
    rsp_gaps_on = 1'b1;
    send_item(kel_pkg::OP_FRAME_UPDATE, 7'd0);
    for (int i = 0; i < 140; i++) begin
      case ($urandom_range(0, 3))
        0:       send_item(kel_pkg::OP_KEY_UP, 7'($urandom_range(0, 15)));
        1:       send_item(kel_pkg::OP_BUTTON_DOWN, 7'($urandom_range(0, 2)));
        default: send_item(kel_pkg::OP_KEY_DOWN, 7'($urandom_range(0, 15)));
      endcase
    end
    for (int i = 0; i < 16; i++) send_item(kel_pkg::OP_QUERY_KEY, 7'(i));
    send_item(kel_pkg::OP_FRAME_UPDATE, 7'd0);
    for (int i = 0; i < 30; i++) begin
      if (i % 2 == 0) send_item(kel_pkg::OP_KEY_DOWN, 7'($urandom_range(0, 15)));
      else send_item(kel_pkg::OP_QUERY_KEY, 7'($urandom_range(0, 15)));
    end
    for (int i = 0; i < 3; i++) send_item(kel_pkg::OP_QUERY_BUTTON, 7'(i));
  endtask

  // Receiver holds off for a long stretch while queries keep coming.
  task automatic test_backpressure();
    req_gaps_on     = 1'b0;
    rsp_gaps_on     = 1'b0;
    rsp_hold_cycles = 300;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 1) send_item(kel_pkg::OP_KEY_DOWN, 7'(i));
      else if (i % 4 == 3) send_item(kel_pkg::OP_QUERY_BUTTON, 7'(i % 3));
      else send_item(kel_pkg::OP_QUERY_KEY, 7'(i));
    end
  endtask

  // Random traffic in blocks with their own code spread, frame rate and idling.
  task automatic test_random(input int count);
    int         roll;
    int         frame_pct;
    bit         wide;
    logic [6:0] key_code;
    logic [6:0] btn_code;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        wide        = ($urandom_range(0, 3) == 0);
        roll        = $urandom_range(0, 2);
        frame_pct   = (roll == 0) ? 0 : ((roll == 1) ? 3 : 10);
        req_gaps_on = ($urandom_range(0, 3) != 0);
        rsp_gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (wide) begin
        key_code = 7'($urandom_range(0, 127));
        btn_code = 7'($urandom_range(0, 127));
      end else begin
        key_code = 7'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(120, 127));
        btn_code = 7'($urandom_range(0, 3));
      end
      if ($urandom_range(0, 99) < frame_pct) begin
        send_item(kel_pkg::OP_FRAME_UPDATE, 7'($urandom_range(0, 127)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 22) send_item(kel_pkg::OP_KEY_DOWN, key_code);
        else if (roll < 40) send_item(kel_pkg::OP_KEY_UP, key_code);
        else if (roll < 50) send_item(kel_pkg::OP_BUTTON_DOWN, btn_code);
        else if (roll < 58) send_item(kel_pkg::OP_BUTTON_UP, btn_code);
        else if (roll < 80) send_item(kel_pkg::OP_QUERY_KEY, key_code);
        else if (roll < 97) send_item(kel_pkg::OP_QUERY_BUTTON, btn_code);
        else send_item(OP_UNUSED, 7'($urandom_range(0, 127)));
      end
    end
  endtask

  initial begin : main
    for (int i = 0; i < kel_pkg::SLOT_COUNT; i++) key_flags[i] = 3'b000;
    for (int i = 0; i < kel_pkg::KEYBOARD_KEYS; i++) key_held[i] = 1'b0;
    for (int i = 0; i < kel_pkg::RING_DEPTH; i++) begin
      log_valid[i] = 1'b0;
      log_slot[i]  = 0;
      log_flags[i] = 3'b000;
    end
    log_ptr         = 0;
    rsp_hold_cycles = 0;
    req_gaps_on     = 1'b0;
    rsp_gaps_on     = 1'b0;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_flag_extremes();
    test_held_key();
    test_ignored_codes();
    test_ring_wrap();
    test_backpressure();
    test_random(RANDOM_ITEMS);
    req_valid <= 1'b0;

    // Let owed results drain, then give a trailing frame walk time to finish.
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d query results over %0d frame updates.",
             items_sent, results_seen, frames_seen);
    $display("Ring wrapped %0d times; %0d repeat presses and %0d bad codes were dropped.",
             wraps_seen, held_skips, range_skips);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
